### sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/ccsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ccsc_pkg;

    localparam int ROUNDS      = 20;
    localparam int DOUBLES     = ROUNDS / 2;
    localparam int NSTEP       = ROUNDS / 2 + ROUNDS % 2;
    localparam int RND_W       = $clog2(NSTEP + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);

    localparam logic [3:0][31:0] SIGMA = {
        32'h6B206574, 32'h79622d32, 32'h3320646E, 32'h61707865
    };

    // configuration register indexes
    localparam logic [2:0] REG_KEY01   = 3'd0;
    localparam logic [2:0] REG_KEY23   = 3'd1;
    localparam logic [2:0] REG_KEY45   = 3'd2;
    localparam logic [2:0] REG_KEY67   = 3'd3;
    localparam logic [2:0] REG_NONCE01 = 3'd4;
    localparam logic [2:0] REG_NONCE2  = 3'd5;
    localparam logic [2:0] REG_CTR     = 3'd6;

    typedef logic [15:0][31:0] blk_t;

    typedef struct packed {
        logic [31:0] nonce0;
        logic [31:0] ctr;
    } tag_t;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [31:0]      nonce1;
        logic [31:0]      nonce2;
    } core_cfg_t;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  valid;
        logic        last;
        logic        need;   // first word of a block
        logic [3:0]  pos;
        tag_t        tag;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    typedef struct packed {
        logic start;
        logic abort;
        tag_t tag;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        tag_t tag;
    } core_stat_t;

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic blk_t quarter(blk_t s, int a, int b, int c, int d);
        blk_t r;
        r = s;
        r[a] = r[a] + r[b]; r[d] = rotl(r[d] ^ r[a], 16);
        r[c] = r[c] + r[d]; r[b] = rotl(r[b] ^ r[c], 12);
        r[a] = r[a] + r[b]; r[d] = rotl(r[d] ^ r[a], 8);
        r[c] = r[c] + r[d]; r[b] = rotl(r[b] ^ r[c], 7);
        return r;
    endfunction

    function automatic blk_t column_round(blk_t s);
        blk_t r;
        r = quarter(s, 0, 4, 8, 12);
        r = quarter(r, 1, 5, 9, 13);
        r = quarter(r, 2, 6, 10, 14);
        r = quarter(r, 3, 7, 11, 15);
        return r;
    endfunction

    function automatic blk_t diagonal_round(blk_t s);
        blk_t r;
        r = quarter(s, 0, 5, 10, 15);
        r = quarter(r, 1, 6, 11, 12);
        r = quarter(r, 2, 7, 8, 13);
        r = quarter(r, 3, 4, 9, 14);
        return r;
    endfunction

    function automatic blk_t init_state(core_cfg_t c, tag_t t);
        blk_t s;
        s[3:0]  = SIGMA;
        s[11:4] = c.key;
        s[12]   = t.ctr;
        s[13]   = t.nonce0;
        s[14]   = c.nonce1;
        s[15]   = c.nonce2;
        return s;
    endfunction

    // counter step with carry into nonce word 0
    function automatic tag_t tag_inc(tag_t t);
        tag_t r;
        r.ctr    = t.ctr + 32'd1;
        r.nonce0 = t.nonce0 + {31'd0, (r.ctr == 32'd0)};
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/ccsc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ccsc_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [39:0]            s_tdata,
    input  wire logic                   s_tlast,
    input  wire logic                   s_tuser,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [63:0]            cfg_data,
    input  wire ccsc_pkg::fifo_stat_t   fstat,
    output logic                        push,
    output ccsc_pkg::entry_t            entry,
    output ccsc_pkg::core_cfg_t         ccfg,
    output logic                        cfg_wr
);
    import ccsc_pkg::*;

    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg, nonce01_reg;
    logic [31:0] nonce2_reg, start_ctr_reg;
    tag_t        tag_reg, tag_next;
    logic [3:0]  pos_reg, pos_next;
    tag_t        eff_tag;
    logic [3:0]  eff_pos;
    logic        last;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign s_tready  = !fstat.full;
    assign push      = s_tvalid && !fstat.full;

    assign ccfg.key    = {key67_reg, key45_reg, key23_reg, key01_reg};
    assign ccfg.nonce1 = nonce01_reg[63:32];
    assign ccfg.nonce2 = nonce2_reg;

    always_comb
    begin
        // restart reloads counter and nonce word 0 before this word
        eff_tag  = s_tuser ? tag_t'{nonce0: nonce01_reg[31:0], ctr: start_ctr_reg} : tag_reg;
        eff_pos  = s_tuser ? 4'd0 : pos_reg;
        last     = s_tlast || (s_tdata[34:32] < 3'd4);
        tag_next = (eff_pos == 4'd0) ? tag_inc(eff_tag) : eff_tag;
        pos_next = last ? 4'd0 : eff_pos + 4'd1;

        entry.data  = s_tdata[31:0];
        entry.valid = s_tdata[34:32];
        entry.last  = last;
        entry.need  = (eff_pos == 4'd0);
        entry.pos   = eff_pos;
        entry.tag   = eff_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
            pos_reg <= '0;
        end
        else if (push)
        begin
            tag_reg <= tag_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg     <= '0;
            key23_reg     <= '0;
            key45_reg     <= '0;
            key67_reg     <= '0;
            nonce01_reg   <= '0;
            nonce2_reg    <= '0;
            start_ctr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KEY01:   key01_reg     <= cfg_data;
                REG_KEY23:   key23_reg     <= cfg_data;
                REG_KEY45:   key45_reg     <= cfg_data;
                REG_KEY67:   key67_reg     <= cfg_data;
                REG_NONCE01: nonce01_reg   <= cfg_data;
                REG_NONCE2:  nonce2_reg    <= cfg_data[31:0];
                REG_CTR:     start_ctr_reg <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/ccsc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module ccsc_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ccsc_pkg::entry_t     wr_entry,
    input  wire logic                 pop,
    output ccsc_pkg::entry_t          head,
    output ccsc_pkg::fifo_stat_t      fstat
);
    import ccsc_pkg::*;

    entry_t           mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign head        = mem_reg[rd_ptr_reg];
    assign fstat.empty = (count_reg == '0);
    assign fstat.full  = (count_reg == (PTR_W+1)'(FIFO_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

### sv/ccsc_core.sv
`timescale 1ns / 1ps
`default_nettype none
module ccsc_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ccsc_pkg::core_ctl_t  ctl,
    input  wire ccsc_pkg::core_cfg_t  ccfg,
    output ccsc_pkg::core_stat_t      cstat,
    output ccsc_pkg::blk_t            blk
);
    import ccsc_pkg::*;

    blk_t             x_reg;
    blk_t             init_s;
    tag_t             tag_reg;
    logic [RND_W-1:0] rnd_reg;
    logic             busy_reg, fin_reg;

    assign cstat.busy = busy_reg;
    assign cstat.done = fin_reg;
    assign cstat.tag  = tag_reg;

    // feed-forward of the input state
    always_comb
    begin
        init_s = init_state(ccfg, tag_reg);
        for (int i = 0; i < 16; i++)
            blk[i] = x_reg[i] + init_s[i];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
            x_reg <= init_state(ccfg, ctl.tag);
        else if (busy_reg && !fin_reg)
            x_reg <= (rnd_reg < RND_W'(DOUBLES)) ? diagonal_round(column_round(x_reg))
                                                 : column_round(x_reg);
        if (ctl.start)
            tag_reg <= ctl.tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            rnd_reg  <= '0;
        end
        else if (ctl.abort)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            rnd_reg  <= '0;
        end
        else if (busy_reg && !fin_reg)
        begin
            rnd_reg <= rnd_reg + RND_W'(1);
            if (rnd_reg == RND_W'(NSTEP - 1))
                fin_reg <= 1'b1;
        end
        else if (fin_reg)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
    end

endmodule
`default_nettype wire

### sv/ccsc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ccsc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ccsc_pkg::entry_t     head,
    input  wire ccsc_pkg::fifo_stat_t fstat,
    output logic                      pop,
    input  wire logic                 cfg_wr,
    input  wire ccsc_pkg::core_stat_t cstat,
    input  wire ccsc_pkg::blk_t       cblk,
    output ccsc_pkg::core_ctl_t       ctl,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [39:0]               m_tdata,
    output logic                      m_tlast
);
    import ccsc_pkg::*;

    blk_t        cur_blk_reg, pf_blk_reg;
    tag_t        pf_tag_reg;
    logic        pf_valid_reg;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_vb_reg;
    logic        out_last_reg;
    logic        avail, hit, can_out, pending;
    logic [31:0] ks, mask;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_vb_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        avail   = !fstat.empty;
        hit     = pf_valid_reg && (pf_tag_reg == head.tag);
        can_out = !out_valid_reg || m_tready;
        pop     = avail && can_out && (!head.need || hit);
        pending = cstat.busy && (cstat.tag == head.tag);

        // on a hit start the next block ahead; on a miss compute this one
        ctl.abort = cfg_wr;
        ctl.start = !cfg_wr && avail && head.need &&
                    ((pop && hit) || (!hit && !pending));
        ctl.tag   = hit ? tag_inc(head.tag) : head.tag;

        ks = head.need ? pf_blk_reg[0] : cur_blk_reg[head.pos];

        case (head.valid)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cstat.done)
        begin
            pf_blk_reg <= cblk;
            pf_tag_reg <= cstat.tag;
        end
        if (pop && head.need)
            cur_blk_reg <= pf_blk_reg;
        if (pop)
        begin
            out_word_reg <= (head.data ^ ks) & mask;
            out_vb_reg   <= head.valid;
            out_last_reg <= head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pf_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head.need)
                pf_valid_reg <= 1'b0;
            if (cstat.done)
                pf_valid_reg <= 1'b1;
            if (cfg_wr)
                pf_valid_reg <= 1'b0;
            if (can_out)
                out_valid_reg <= pop;
        end
    end

endmodule
`default_nettype wire

### sv/chacha20_stream_cipher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ChaCha20 stream cipher, one 32-bit little-endian word per beat.
// Input stream (s_*): tdata holds data_word and valid_bytes, tlast marks the
// end of a buffer, tuser is the restart flag. Output stream (m_*): tdata holds
// out_word and out_valid_bytes, tlast is set on the word that ended a buffer.
// Config port (cfg_*): register index and 64-bit data, always ready; write only
// while the stream is idle. A write drops any keystream block computed ahead.
// When the keystream block is on hand, a word passes through the queue entry
// and the output register. Throughput: 1 word per cycle while m_tready allows
// and the block is on hand. The round engine does one double round per cycle.
// It runs one block ahead with counter+1, so words that carry on the counter
// stream at full rate as long as the engine finishes that block while the
// block before is still being served. A restart, a block needed before the
// engine is done with it, or the very first block waits for the engine.
// A 4-entry queue separates the classifying front from the keystream back,
// so the input keeps flowing while the output is stalled until the queue
// fills; the output register holds its word while m_tready is low.
// Reset clears counter, nonce word 0, word position and config registers.
`include "assert_macros.svh"
module chacha20_stream_cipher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] data_word, [34:32] valid_bytes
    input  wire logic        s_tlast,   // end_of_buffer
    input  wire logic        s_tuser,   // restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] out_word, [34:32] out_valid_bytes
    output logic             m_tlast,   // out_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import ccsc_pkg::*;

    entry_t     wr_entry, head;
    fifo_stat_t fstat;
    logic       push, pop, cfg_wr;
    core_cfg_t  ccfg;
    core_ctl_t  ctl;
    core_stat_t cstat;
    blk_t       cblk;

    ccsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fstat     (fstat),
        .push      (push),
        .entry     (wr_entry),
        .ccfg      (ccfg),
        .cfg_wr    (cfg_wr)
    );

    ccsc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .fstat    (fstat)
    );

    ccsc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .ccfg  (ccfg),
        .cstat (cstat),
        .blk   (cblk)
    );

    ccsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .fstat    (fstat),
        .pop      (pop),
        .cfg_wr   (cfg_wr),
        .cstat    (cstat),
        .cblk     (cblk),
        .ctl      (ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a config write cancels any block in flight
    `ASSERT_NEXT(a_cfg_abort, clk, rst_n, cfg_valid && cfg_ready, !cstat.busy)
    // an accepted word lands in the queue
    `ASSERT_NEXT(a_push_lands, clk, rst_n, s_tvalid && s_tready && fstat.empty, !fstat.empty)
    // a finished block comes only from a running engine
    `ASSERT_IMP(a_done_busy, clk, rst_n, cstat.done, cstat.busy)

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

import ccsc_pkg::*;

// One output word as the block should present it.
typedef struct {
    bit [31:0] word;
    bit [2:0]  nbytes;
    bit        last;
} cipher_word_t;

// Keystream predictor plus in-order checker of the output stream.
class cipher_scoreboard;
    bit [31:0]    key_word [8];
    bit [31:0]    cfg_nonce0;
    bit [31:0]    cfg_nonce1;
    bit [31:0]    cfg_nonce2;
    bit [31:0]    cfg_counter;
    bit [31:0]    block_ctr;
    bit [31:0]    nonce0_run;
    bit [3:0]     word_pos;
    bit [31:0]    keystream [16];
    bit [31:0]    mix [16];
    cipher_word_t expected_words [$];
    int           failures;

    function bit [31:0] rol32(bit [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function void qround(int a, int b, int c, int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
    endfunction

    function void column_pass();
        qround(0, 4, 8, 12);
        qround(1, 5, 9, 13);
        qround(2, 6, 10, 14);
        qround(3, 7, 11, 15);
    endfunction

    function void diagonal_pass();
        qround(0, 5, 10, 15);
        qround(1, 6, 11, 12);
        qround(2, 7, 8, 13);
        qround(3, 4, 9, 14);
    endfunction

    // Next 64-byte keystream block, then counter step with carry.
    function void make_keystream_block();
        bit [31:0] seed [16];
        int        i;
        seed[0]  = 32'h61707865;
        seed[1]  = 32'h3320646E;
        seed[2]  = 32'h79622d32;
        seed[3]  = 32'h6B206574;
        for (i = 0; i < 8; i++)
            seed[4 + i] = key_word[i];
        seed[12] = block_ctr;
        seed[13] = nonce0_run;
        seed[14] = cfg_nonce1;
        seed[15] = cfg_nonce2;
        mix = seed;
        for (i = 0; i < ROUNDS / 2; i++)
        begin
            column_pass();
            diagonal_pass();
        end
        if (ROUNDS % 2 != 0)
            column_pass();
        for (i = 0; i < 16; i++)
            keystream[i] = mix[i] + seed[i];
        block_ctr = block_ctr + 32'd1;
        if (block_ctr == 32'd0)
            nonce0_run = nonce0_run + 32'd1;
    endfunction

    function void write_reg(bit [2:0] idx, bit [63:0] value);
        case (idx)
            REG_KEY01:
            begin
                key_word[0] = value[31:0];
                key_word[1] = value[63:32];
            end
            REG_KEY23:
            begin
                key_word[2] = value[31:0];
                key_word[3] = value[63:32];
            end
            REG_KEY45:
            begin
                key_word[4] = value[31:0];
                key_word[5] = value[63:32];
            end
            REG_KEY67:
            begin
                key_word[6] = value[31:0];
                key_word[7] = value[63:32];
            end
            REG_NONCE01:
            begin
                cfg_nonce0 = value[31:0];
                cfg_nonce1 = value[63:32];
            end
            REG_NONCE2: cfg_nonce2  = value[31:0];
            REG_CTR:    cfg_counter = value[31:0];
            default: ;
        endcase
    endfunction

    function void accept_plain_word(bit [31:0] data, bit [2:0] nbytes, bit eob, bit restart);
        cipher_word_t exp_w;
        bit [31:0]    ks;
        bit [31:0]    mask;
        int           n;
        if (restart)
        begin
            block_ctr  = cfg_counter;
            nonce0_run = cfg_nonce0;
            word_pos   = 4'd0;
        end
        if (word_pos == 4'd0)
            make_keystream_block();
        ks = keystream[word_pos];
        // counts above four mask like four but do not close the buffer
        n = (nbytes > 3'd4) ? 4 : int'(nbytes);
        mask = (n == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
        exp_w.word   = (data ^ ks) & mask;
        exp_w.nbytes = nbytes;
        exp_w.last   = eob || (nbytes < 3'd4);
        word_pos = exp_w.last ? 4'd0 : word_pos + 4'd1;
        expected_words.push_back(exp_w);
    endfunction

    function void check_cipher_word(bit [31:0] word, bit [2:0] nbytes, bit last);
        cipher_word_t exp_w;
        if (expected_words.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected output word %08h bytes %0d last %0b",
                         word, nbytes, last);
            return;
        end
        exp_w = expected_words.pop_front();
        if (exp_w.word != word || exp_w.nbytes != nbytes || exp_w.last != last)
        begin
            failures++;
            if (failures <= 10)
                $display("mismatch: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                         exp_w.word, exp_w.nbytes, exp_w.last, word, nbytes, last);
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module tb_top;

    // generous for the ~700 words sent, even in the worst case
    localparam int CYCLE_LIMIT = 200000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;    // [31:0] data_word, [34:32] valid_bytes
    logic        s_tlast   = 1'b0;  // end_of_buffer
    logic        s_tuser   = 1'b0;  // restart
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // [31:0] out_word, [34:32] out_valid_bytes
    logic        m_tlast;           // out_last
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    cipher_scoreboard sb = new;

    bit idle_on  = 1'b1;  // random gaps on both sides when set
    int hold_req = 0;     // cycles of output back-pressure requested
    int cycles   = 0;

    always #4 clk = ~clk;

    chacha20_stream_cipher_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function int draw_gap();
        return idle_on ? int'($urandom_range(0, 4)) : 0;
    endfunction

    // Offer one plaintext word; returns right after the accepting edge.
    // tvalid stays high across back-to-back words (gap of zero).
    task send_word(bit [31:0] data, bit [2:0] nbytes, bit eob, bit restart);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, nbytes, data};
        s_tlast  <= eob;
        s_tuser  <= restart;
        do @(posedge clk); while (!s_tready);
        sb.accept_plain_word(data, nbytes, eob, restart);
    endtask

    // Well-formed buffer: full words, closed by a short word or tlast.
    task send_buffer(int len, bit restart);
        int i;
        for (i = 0; i < len - 1; i++)
            send_word($urandom, 3'd4, 1'b0, restart && (i == 0));
        if ($urandom_range(0, 3) == 0)
            send_word($urandom, 3'd4, 1'b1, restart && (len == 1));
        else
            send_word($urandom, 3'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                      restart && (len == 1));
    endtask

    // Sender goes quiet until every predicted word has come out.
    task drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task write_reg(bit [2:0] idx, bit [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task load_settings(bit [63:0] k01, bit [63:0] k23, bit [63:0] k45, bit [63:0] k67,
                       bit [63:0] n01, bit [31:0] n2, bit [31:0] ctr);
        write_reg(REG_KEY01, k01);
        write_reg(REG_KEY23, k23);
        write_reg(REG_KEY45, k45);
        write_reg(REG_KEY67, k67);
        write_reg(REG_NONCE01, n01);
        write_reg(REG_NONCE2, {32'd0, n2});
        write_reg(REG_CTR, {32'd0, ctr});
        cfg_valid <= 1'b0;
    endtask

    // Output side: random stalls per word, plus one long hold-off on request.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap();
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_cipher_word(m_tdata[31:0], m_tdata[34:32], m_tlast);
        end
    end

    initial
    begin
        bit [63:0] k01, k23, k45, k67, n01;
        bit [31:0] n2, ctr;
        int        i;
        int        ph;
        int        sent;
        int        len;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte-sequence key 00..1f, nonce 09/4a/00, counter 1.
        load_settings(64'h07060504_03020100, 64'h0f0e0d0c_0b0a0908,
                      64'h17161514_13121110, 64'h1f1e1d1c_1b1a1918,
                      64'h4a000000_09000000, 32'h0000_0000, 32'h0000_0001);
        send_word(32'h0000_0000, 3'd4, 1'b0, 1'b1);
        // walk the rest of the block and into the next one
        for (i = 1; i < 16; i++)
            send_word(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd3, 1'b0, 1'b0);   // short word ends buffer
        send_word(32'hFFFF_FFFF, 3'd2, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0);   // zero bytes: all masked
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0);
        send_word(32'hA5A5_5A5A, 3'd5, 1'b0, 1'b0);   // over-range counts
        send_word(32'h5A5A_A5A5, 3'd6, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0);
        send_word(32'h1234_5678, 3'd4, 1'b0, 1'b0);
        send_word(32'h9ABC_DEF0, 3'd4, 1'b0, 1'b1);   // restart mid-buffer

        // Random phases, each under a fresh register setting.
        for (ph = 1; ph <= 8; ph++)
        begin
            drain();
            k01 = {$urandom, $urandom};
            k23 = {$urandom, $urandom};
            k45 = {$urandom, $urandom};
            k67 = {$urandom, $urandom};
            n01 = {$urandom, $urandom};
            n2  = $urandom;
            ctr = $urandom;
            case (ph)
                1:
                begin
                    k01 = '0; k23 = '0; k45 = '0; k67 = '0; n01 = '0; n2 = '0; ctr = '0;
                end
                2:
                begin
                    // counter and nonce word 0 both wrap on the second block
                    k01 = '1; k23 = '1; k45 = '1; k67 = '1; n01 = '1; n2 = '1; ctr = '1;
                end
                3: ctr = 32'hFFFF_FFFE;
                default: ;
            endcase
            load_settings(k01, k23, k45, k67, n01, n2, ctr);

            idle_on = (ph % 3 != 0);
            if (ph == 4)
            begin
                // long output stall while the input runs flat out
                idle_on  = 1'b0;
                hold_req = 150;
            end

            sent = 0;
            while (sent < 72)
            begin
                if (sent != 0 && $urandom_range(0, 9) == 0)
                begin
                    send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 7) == 0);
                    sent++;
                end
                else
                begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 70)
                                                      : $urandom_range(1, 20);
                    // first buffer of ph 1 to 3 restarts; others often carry on the counter
                    send_buffer(len, (sent == 0 && ph <= 3) || $urandom_range(0, 2) == 0);
                    sent += len;
                end
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
